FILE: src/vgaac_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes, register numbers and initial value tables
// for the VGA attribute controller. No dependencies.
`default_nettype none

package vgaac_pkg;

   // command codes
   localparam logic [2:0] CMD_PORT_WRITE    = 3'd0;
   localparam logic [2:0] CMD_DATA_READ     = 3'd1;
   localparam logic [2:0] CMD_INDEX_READ    = 3'd2;
   localparam logic [2:0] CMD_FLIPFLOP_RST  = 3'd3;
   localparam logic [2:0] CMD_BACKDOOR_SET  = 3'd4;
   localparam logic [2:0] CMD_BACKDOOR_GET  = 3'd5;
   localparam logic [2:0] CMD_INIT          = 3'd6;

   // register numbers
   localparam logic [4:0] REG_MODE     = 5'h10;
   localparam logic [4:0] REG_PLANE    = 5'h12;
   localparam logic [4:0] REG_PAN      = 5'h13;
   localparam logic [4:0] REG_CSEL     = 5'h14;
   localparam logic [4:0] PALETTE_LAST = 5'h0f;

   localparam logic [7:0] MASK_MODE    = 8'hef;
   localparam logic [7:0] MASK_NIBBLE  = 8'h0f;
   localparam logic [7:0] MASK_DEFAULT = 8'h3f;
   localparam logic [7:0] BYTE_NONE    = 8'hff;

   localparam int DIRTY_W     = 21;
   localparam int TBL_COUNT   = 9;
   localparam int TBL_ENTRIES = 21;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] data_in;
      logic [7:0] reg_index;
      logic [3:0] table_select;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic               flipflop_state;
      logic               screen_blank;
      logic               color_changed;
      logic [DIRTY_W-1:0] dirty_mask;
      logic               plane_enable_changed;
   } rsp_type;

   // register-file control state outside the RAM
   typedef struct packed {
      logic [4:0] cur_index;
      logic       pal_access;
      logic       phase;
      logic       blank;
      logic       color_changed;
   } ctrl_type;

   localparam ctrl_type CTRL_RESET = '{
      cur_index: 5'd0, pal_access: 1'b1, phase: 1'b0, blank: 1'b0, color_changed: 1'b1
   };

   localparam logic [7:0] INIT_TABLES [TBL_COUNT][TBL_ENTRIES] = '{
      '{8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h14,8'h07,8'h38,8'h39,8'h3a,8'h3b,8'h3c,
        8'h3d,8'h3e,8'h3f,8'h0c,8'h00,8'h0f,8'h08,8'h00},
      '{8'h00,8'h13,8'h15,8'h17,8'h02,8'h04,8'h06,8'h07,8'h10,8'h11,8'h12,8'h13,8'h14,
        8'h15,8'h16,8'h17,8'h01,8'h00,8'h03,8'h00,8'h00},
      '{8'h00,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,8'h17,
        8'h17,8'h17,8'h17,8'h01,8'h00,8'h01,8'h00,8'h00},
      '{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h08,8'h10,8'h18,8'h18,8'h18,8'h18,
        8'h18,8'h18,8'h18,8'h0e,8'h00,8'h0f,8'h08,8'h00},
      '{8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h10,8'h11,8'h12,8'h13,8'h14,
        8'h15,8'h16,8'h17,8'h01,8'h00,8'h0f,8'h00,8'h00},
      '{8'h00,8'h08,8'h00,8'h00,8'h18,8'h18,8'h00,8'h00,8'h00,8'h08,8'h00,8'h00,8'h00,
        8'h18,8'h00,8'h00,8'h0b,8'h00,8'h05,8'h00,8'h00},
      '{8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h14,8'h07,8'h38,8'h39,8'h3a,8'h3b,8'h3c,
        8'h3d,8'h3e,8'h3f,8'h01,8'h00,8'h0f,8'h00,8'h00},
      '{8'h00,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,8'h3f,
        8'h3f,8'h3f,8'h3f,8'h01,8'h00,8'h01,8'h00,8'h00},
      '{8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,
        8'h0d,8'h0e,8'h0f,8'h41,8'h00,8'h0f,8'h00,8'h00}
   };

   // value an entry holds after init with the given table; zero past the table
   function automatic logic [7:0] init_value(logic [3:0] tbl, logic [4:0] idx);
      logic [7:0] v;
      v = 8'h00;
      if (tbl < 4'(TBL_COUNT) && idx < 5'(TBL_ENTRIES)) begin
         v = INIT_TABLES[tbl][idx];
      end
      return v;
   endfunction

   function automatic logic [7:0] mask_value(logic [4:0] idx, logic [7:0] v);
      logic [7:0] m;
      if (idx == REG_MODE) begin
         m = v & MASK_MODE;
      end else if (idx == REG_PAN || idx == REG_CSEL) begin
         m = v & MASK_NIBBLE;
      end else begin
         m = v & MASK_DEFAULT;
      end
      return m;
   endfunction

   // register an item touches: backdoor commands name it, the rest use the index
   function automatic logic [4:0] entry_index(req_type item, logic [4:0] cur);
      logic [4:0] idx;
      if (item.cmd == CMD_BACKDOOR_SET || item.cmd == CMD_BACKDOOR_GET) begin
         idx = item.reg_index[4:0];
      end else begin
         idx = cur;
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

FILE: src/vga_attribute_controller.sv
`timescale 1ns / 1ps
// VGA attribute controller, top level. Depends on vgaac_pkg, vgaac_ram and
// vgaac_update.
//
// Usage: one request transaction on req_* (command plus operands) gives
// exactly one response transaction on rsp_* carrying the read byte and the
// flip-flop, screen-blank, color-changed, dirty and plane-change status.
// The register bytes live in a RAM with a registered read. An accepted
// request reads its entry in the accept cycle, then executes in the execute
// state and, once the response register is free, writes back and loads
// the response register, which drives rsp_valid. req_stall stays high in
// execute, so the block takes no new request before the last one has
// finished its RAM read-modify-write. Init does not sweep the RAM:
// per-entry valid flags are cleared at once and an entry without a flag
// reads from the selected table, so init takes no longer than any other
// request.
// A response that is stalled stays in its register; one further request is
// still taken and waits in execute until the register frees up.
// Reset (synchronous) loads the text-mode table, marks all registers dirty,
// sets palette access and color-changed, clears the flip-flop and drops
// any response. req_stall is high during reset.
`default_nettype none

module vga_attribute_controller #(
   parameter int NUM_REGS = 21
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire vgaac_pkg::req_type req_data,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      vgaac_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(NUM_REGS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                state_ff, state_in;
   vgaac_pkg::req_type  item_ff, item_in;
   vgaac_pkg::ctrl_type ctrl_ff, ctrl_in;
   logic [NUM_REGS-1:0] dirty_ff, dirty_in;
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic [3:0]          tbl_ff, tbl_in;
   vgaac_pkg::rsp_type  rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                accept;
   logic                finish;
   logic [4:0]          idx_sel;
   logic [ADDR_W-1:0]   rd_addr;
   logic [7:0]          ram_rd_data;
   logic                ram_we;

   vgaac_pkg::ctrl_type ctrl_nx;
   logic [NUM_REGS-1:0] dirty_nx;
   logic [3:0]          tbl_nx;
   logic                init_all;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [7:0]          wr_data;
   logic [7:0]          read_byte;
   logic                pulse;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign finish    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign ram_we    = finish && wr_en;

   // address held through execute so the registered read stays put while waiting
   always_comb begin
      if (state_ff == ST_IDLE) begin
         idx_sel = vgaac_pkg::entry_index(req_data, ctrl_ff.cur_index);
      end else begin
         idx_sel = vgaac_pkg::entry_index(item_ff, ctrl_ff.cur_index);
      end
      rd_addr = ({1'b0, idx_sel} < 6'(NUM_REGS)) ? idx_sel[ADDR_W-1:0] : '0;
   end

   vgaac_ram #(
      .WIDTH (8),
      .DEPTH (NUM_REGS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   vgaac_update #(
      .NUM_REGS (NUM_REGS)
   ) u_update (
      .item        (item_ff),
      .ctrl_cur    (ctrl_ff),
      .dirty_cur   (dirty_ff),
      .tbl_cur     (tbl_ff),
      .entry_valid (valid_ff[rd_addr]),
      .ram_rd_data (ram_rd_data),
      .ctrl_nx     (ctrl_nx),
      .dirty_nx    (dirty_nx),
      .tbl_nx      (tbl_nx),
      .init_all    (init_all),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .read_byte   (read_byte),
      .pulse       (pulse)
   );

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      ctrl_in      = ctrl_ff;
      dirty_in     = dirty_ff;
      valid_in     = valid_ff;
      tbl_in       = tbl_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         item_in  = req_data;
         state_in = ST_EXEC;
      end

      if (finish) begin
         state_in     = ST_IDLE;
         ctrl_in      = ctrl_nx;
         dirty_in     = dirty_nx;
         tbl_in       = tbl_nx;
         rsp_valid_in = 1'b1;
         if (init_all) begin
            valid_in = '0;
         end else if (wr_en) begin
            valid_in[wr_addr] = 1'b1;
         end
         rsp_in.read_data            = read_byte;
         rsp_in.flipflop_state       = ctrl_nx.phase;
         rsp_in.screen_blank         = ctrl_nx.blank;
         rsp_in.color_changed        = ctrl_nx.color_changed;
         rsp_in.dirty_mask           = dirty_nx[vgaac_pkg::DIRTY_W-1:0];
         rsp_in.plane_enable_changed = pulse;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_ff      <= vgaac_pkg::CTRL_RESET;
         dirty_ff     <= '1;
         valid_ff     <= '0;
         tbl_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         dirty_ff     <= dirty_in;
         valid_ff     <= valid_in;
         tbl_ff       <= tbl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: src/vgaac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vgaac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 21
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/vgaac_update.sv
`timescale 1ns / 1ps
// Command execution for the attribute controller: next control state, dirty
// marks, RAM write-back and read result. Depends on vgaac_pkg.
`default_nettype none

module vgaac_update #(
   parameter int NUM_REGS = 21
) (
   input  wire vgaac_pkg::req_type               item,
   input  wire vgaac_pkg::ctrl_type              ctrl_cur,
   input  wire logic [NUM_REGS-1:0]              dirty_cur,
   input  wire logic [3:0]                       tbl_cur,
   input  wire logic                             entry_valid,
   input  wire logic [7:0]                       ram_rd_data,
   output      vgaac_pkg::ctrl_type              ctrl_nx,
   output      logic [NUM_REGS-1:0]              dirty_nx,
   output      logic [3:0]                       tbl_nx,
   output      logic                             init_all,
   output      logic                             wr_en,
   output      logic [$clog2(NUM_REGS)-1:0]      wr_addr,
   output      logic [7:0]                       wr_data,
   output      logic [7:0]                       read_byte,
   output      logic                             pulse
);

   localparam int ADDR_W = $clog2(NUM_REGS);

   logic [4:0] eidx;
   logic       eidx_ok;
   logic       ridx_ok;
   logic [7:0] old_val;
   logic [7:0] idx_byte;
   logic       cur_access;
   logic       dw_go;
   logic       dw_pal;
   logic [7:0] masked;

   always_comb begin
      eidx     = vgaac_pkg::entry_index(item, ctrl_cur.cur_index);
      eidx_ok  = {1'b0, eidx} < 6'(NUM_REGS);
      ridx_ok  = item.reg_index < 8'(NUM_REGS);
      // entries never written since reset or init read from the loaded table
      old_val  = entry_valid ? ram_rd_data : vgaac_pkg::init_value(tbl_cur, eidx);
      idx_byte = {2'b00, ctrl_cur.pal_access, ctrl_cur.cur_index};
      cur_access = eidx_ok && (!ctrl_cur.pal_access || eidx > vgaac_pkg::PALETTE_LAST);
      masked   = vgaac_pkg::mask_value(eidx, item.data_in);
      dw_pal   = (item.cmd == vgaac_pkg::CMD_BACKDOOR_SET) ? 1'b0 : ctrl_cur.pal_access;
      dw_go    = (item.cmd == vgaac_pkg::CMD_PORT_WRITE && ctrl_cur.phase) ||
                 (item.cmd == vgaac_pkg::CMD_BACKDOOR_SET && ridx_ok);

      ctrl_nx   = ctrl_cur;
      dirty_nx  = dirty_cur;
      tbl_nx    = tbl_cur;
      init_all  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = eidx[ADDR_W-1:0];
      wr_data   = masked;
      read_byte = 8'h00;
      pulse     = 1'b0;

      case (item.cmd)
         vgaac_pkg::CMD_PORT_WRITE: begin
            if (!ctrl_cur.phase) begin
               ctrl_nx.phase      = 1'b1;
               ctrl_nx.cur_index  = item.data_in[4:0];
               ctrl_nx.pal_access = item.data_in[5];
               ctrl_nx.blank      = !item.data_in[5];
            end
         end
         vgaac_pkg::CMD_DATA_READ: begin
            read_byte = cur_access ? old_val : idx_byte;
         end
         vgaac_pkg::CMD_INDEX_READ: begin
            read_byte = idx_byte;
         end
         vgaac_pkg::CMD_FLIPFLOP_RST: begin
            ctrl_nx.phase = 1'b0;
         end
         vgaac_pkg::CMD_BACKDOOR_SET: begin
            if (ridx_ok) begin
               ctrl_nx.cur_index = item.reg_index[4:0];
            end
         end
         vgaac_pkg::CMD_BACKDOOR_GET: begin
            read_byte = ridx_ok ? old_val : vgaac_pkg::BYTE_NONE;
         end
         vgaac_pkg::CMD_INIT: begin
            init_all                = 1'b1;
            tbl_nx = (item.table_select < 4'(vgaac_pkg::TBL_COUNT)) ? item.table_select : 4'd0;
            dirty_nx                = '1;
            ctrl_nx.color_changed   = 1'b1;
            ctrl_nx.cur_index       = 5'd0;
            ctrl_nx.pal_access      = 1'b1;
            ctrl_nx.phase           = 1'b0;
         end
         default: begin
         end
      endcase

      // data-phase write, shared by port write and backdoor set
      if (dw_go) begin
         ctrl_nx.phase = 1'b0;
         if (eidx_ok && (!dw_pal || eidx > vgaac_pkg::PALETTE_LAST)) begin
            if (old_val != masked) begin
               wr_en                     = 1'b1;
               dirty_nx[eidx[ADDR_W-1:0]] = 1'b1;
               ctrl_nx.color_changed     = 1'b1;
               pulse                     = (eidx == vgaac_pkg::REG_PLANE);
            end
            if (eidx == vgaac_pkg::REG_MODE || eidx == vgaac_pkg::REG_CSEL) begin
               dirty_nx[15:0] = '1;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/vgaac_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the attribute controller and its bind to the top
// level. Depends on vgaac_pkg.
`default_nettype none

module vgaac_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire vgaac_pkg::req_type req_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire vgaac_pkg::rsp_type rsp_data
);

   // reset drops any pending response
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one transaction in flight: intake closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one executes");

   // a fresh response follows a request that was accepted
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without matching request");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_data)))
      else $error("stalled request changed");

endmodule

bind vga_attribute_controller vgaac_checker u_vgaac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for vga_attribute_controller: directed and random register-file
// accesses, each response checked against a behavioral model of the attribute registers.
// Depends on vgaac_pkg and the controller RTL.
`default_nettype none

module testbench;

   localparam int REG_COUNT = vgaac_pkg::DIRTY_W;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam logic [vgaac_pkg::DIRTY_W-1:0] PALETTE_DIRTY = 21'h00ffff;
   localparam logic [vgaac_pkg::DIRTY_W-1:0] ALL_DIRTY = '1;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 190;
   localparam int MAX_REPORTS = 10;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   vgaac_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   vgaac_pkg::rsp_type rsp_data;

   vga_attribute_controller uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   vgaac_pkg::req_type access_backlog[$];
   vgaac_pkg::rsp_type status_due[$];
   int      items_queued = 0;
   int      mismatch_count = 0;
   int      sender_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   // model of the attribute register file
   logic [7:0]                   attr_file [REG_COUNT];
   logic [vgaac_pkg::DIRTY_W-1:0] dirty_bits;
   logic [4:0]                   cur_index;
   logic                         pal_access;
   logic                         ff_data;
   logic                         blank;
   logic                         color_changed;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void load_attr_table(logic [3:0] sel);
      int t;
      t = (sel < vgaac_pkg::TBL_COUNT) ? int'(sel) : 0;
      for (int j = 0; j < REG_COUNT; j++)
         attr_file[j] = (j < vgaac_pkg::TBL_ENTRIES) ? vgaac_pkg::INIT_TABLES[t][j] : 8'h00;
      dirty_bits = ALL_DIRTY;
      color_changed = 1'b1;
      cur_index = 5'd0;
      pal_access = 1'b1;
      ff_data = 1'b0;
   endfunction

   // data-phase write at cur_index; returns 1 when the plane enable register changed
   function automatic logic attr_write(logic [7:0] v, logic pal_on);
      logic [7:0] m;
      logic       plane_hit;
      plane_hit = 1'b0;
      ff_data = 1'b0;
      case (cur_index)
         vgaac_pkg::REG_MODE: m = v & vgaac_pkg::MASK_MODE;
         vgaac_pkg::REG_PAN, vgaac_pkg::REG_CSEL: m = v & vgaac_pkg::MASK_NIBBLE;
         default: m = v & vgaac_pkg::MASK_DEFAULT;
      endcase
      if (cur_index < REG_COUNT && (!pal_on || cur_index > vgaac_pkg::PALETTE_LAST)) begin
         if (attr_file[cur_index] != m) begin
            attr_file[cur_index] = m;
            dirty_bits[cur_index] = 1'b1;
            color_changed = 1'b1;
            plane_hit = (cur_index == vgaac_pkg::REG_PLANE);
         end
         if (cur_index == vgaac_pkg::REG_MODE || cur_index == vgaac_pkg::REG_CSEL)
            dirty_bits |= PALETTE_DIRTY;
      end
      return plane_hit;
   endfunction

   function automatic vgaac_pkg::rsp_type attr_predict(vgaac_pkg::req_type t);
      vgaac_pkg::rsp_type r;
      logic [7:0]         idx_byte;
      r = '0;
      idx_byte = {2'b00, pal_access, cur_index};
      case (t.cmd)
         vgaac_pkg::CMD_PORT_WRITE: begin
            if (!ff_data) begin
               ff_data = 1'b1;
               cur_index = t.data_in[4:0];
               pal_access = t.data_in[5];
               blank = ~t.data_in[5];
            end else begin
               r.plane_enable_changed = attr_write(t.data_in, pal_access);
            end
         end
         vgaac_pkg::CMD_DATA_READ: begin
            if (cur_index < REG_COUNT &&
                (!pal_access || cur_index > vgaac_pkg::PALETTE_LAST))
               r.read_data = attr_file[cur_index];
            else
               r.read_data = idx_byte;
         end
         vgaac_pkg::CMD_INDEX_READ: r.read_data = idx_byte;
         vgaac_pkg::CMD_FLIPFLOP_RST: ff_data = 1'b0;
         vgaac_pkg::CMD_BACKDOOR_SET: begin
            if (t.reg_index < REG_COUNT) begin
               cur_index = t.reg_index[4:0];
               r.plane_enable_changed = attr_write(t.data_in, 1'b0);
            end
         end
         vgaac_pkg::CMD_BACKDOOR_GET: begin
            if (t.reg_index < REG_COUNT)
               r.read_data = attr_file[t.reg_index[4:0]];
            else
               r.read_data = vgaac_pkg::BYTE_NONE;
         end
         vgaac_pkg::CMD_INIT: load_attr_table(t.table_select);
         default: ;
      endcase
      r.flipflop_state = ff_data;
      r.screen_blank = blank;
      r.color_changed = color_changed;
      r.dirty_mask = dirty_bits;
      return r;
   endfunction

   function automatic void push_access(logic [2:0] cmd, logic [7:0] data,
                                       logic [7:0] ridx, logic [3:0] tsel);
      vgaac_pkg::req_type t;
      t.cmd = cmd;
      t.data_in = data;
      t.reg_index = ridx;
      t.table_select = tsel;
      access_backlog.push_back(t);
      items_queued++;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // register number, mostly inside the file
   function automatic logic [7:0] rand_reg();
      if ($urandom_range(7) == 0)
         return rand_byte();
      return 8'($urandom_range(REG_COUNT - 1));
   endfunction

   // one short access sequence; most are index write then data access
   task automatic push_sequence();
      logic [7:0] ib;
      int         kind;
      kind = $urandom_range(99);
      if (kind < 15) begin
         push_access(3'($urandom_range(7)), rand_byte(), rand_byte(),
                     4'($urandom_range(15)));
      end else if (kind < 25) begin
         push_access($urandom_range(1) ? vgaac_pkg::CMD_BACKDOOR_SET
                                       : vgaac_pkg::CMD_BACKDOOR_GET,
                     rand_byte(), rand_reg(), 4'($urandom_range(15)));
      end else if (kind < 28) begin
         push_access(vgaac_pkg::CMD_INIT, rand_byte(), rand_byte(), 4'($urandom_range(15)));
      end else begin
         // skipping the flip-flop reset now and then gives broken sequences
         if ($urandom_range(3) != 0)
            push_access(vgaac_pkg::CMD_FLIPFLOP_RST, rand_byte(), rand_byte(),
                        4'($urandom_range(15)));
         ib = {2'($urandom_range(3)), 1'($urandom_range(1)),
               ($urandom_range(9) == 0) ? 5'($urandom_range(31))
                                        : 5'($urandom_range(REG_COUNT - 1))};
         push_access(vgaac_pkg::CMD_PORT_WRITE, ib, rand_byte(), 4'($urandom_range(15)));
         case ($urandom_range(3))
            0, 1: push_access(vgaac_pkg::CMD_PORT_WRITE, rand_byte(), rand_byte(),
                              4'($urandom_range(15)));
            2: push_access(vgaac_pkg::CMD_DATA_READ, rand_byte(), rand_byte(),
                           4'($urandom_range(15)));
            default: begin
               push_access(vgaac_pkg::CMD_INDEX_READ, rand_byte(), rand_byte(),
                           4'($urandom_range(15)));
               push_access(vgaac_pkg::CMD_PORT_WRITE, rand_byte(), rand_byte(),
                           4'($urandom_range(15)));
            end
         endcase
         if ($urandom_range(2) == 0)
            push_access(vgaac_pkg::CMD_DATA_READ, rand_byte(), rand_byte(),
                        4'($urandom_range(15)));
      end
   endtask

   task automatic wait_quiet();
      while (access_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int send_idle, int recv_stall, int quota);
      int start;
      sender_idle_pct = send_idle;
      recv_stall_pct = recv_stall;
      start = items_queued;
      while (items_queued - start < quota) begin
         push_sequence();
         // now and then the sender holds back until all responses are in
         if ($urandom_range(39) == 0)
            wait_quiet();
      end
      wait_quiet();
   endtask

   task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
   endtask

   // request driver: predicts on each accepted transaction, drives at the falling edge
   always begin : req_driver
      logic took;
      @(posedge clock);
      took = !reset && req_valid && !req_stall;
      if (took)
         status_due.push_back(attr_predict(req_data));
      @(negedge clock);
      if (!reset && (took || !req_valid)) begin
         if (access_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_data <= access_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: random, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      vgaac_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (status_due.size() == 0) begin
            flag_field("unexpected transaction, read_data", 32'd0,
                       32'(rsp_data.read_data));
         end else begin
            want = status_due.pop_front();
            if (rsp_data.read_data !== want.read_data)
               flag_field("read_data", 32'(want.read_data), 32'(rsp_data.read_data));
            if (rsp_data.flipflop_state !== want.flipflop_state)
               flag_field("flipflop_state", 32'(want.flipflop_state),
                          32'(rsp_data.flipflop_state));
            if (rsp_data.screen_blank !== want.screen_blank)
               flag_field("screen_blank", 32'(want.screen_blank),
                          32'(rsp_data.screen_blank));
            if (rsp_data.color_changed !== want.color_changed)
               flag_field("color_changed", 32'(want.color_changed),
                          32'(rsp_data.color_changed));
            if (rsp_data.dirty_mask !== want.dirty_mask)
               flag_field("dirty_mask", 32'(want.dirty_mask), 32'(rsp_data.dirty_mask));
            if (rsp_data.plane_enable_changed !== want.plane_enable_changed)
               flag_field("plane_enable_changed", 32'(want.plane_enable_changed),
                          32'(rsp_data.plane_enable_changed));
         end
      end
   end

   initial begin
      load_attr_table(4'd0);
      blank = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, masks, palette lockout, out-of-range, backdoor, init
      push_access(vgaac_pkg::CMD_INDEX_READ, 8'h00, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_DATA_READ, 8'hff, 8'hff, 4'hf);
      push_access(vgaac_pkg::CMD_BACKDOOR_GET, 8'h00, 8'd0, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_GET, 8'h00, 8'd20, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_GET, 8'h00, 8'd21, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_GET, 8'hff, 8'hff, 4'hf);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h00, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'hff, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_DATA_READ, 8'h00, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'hd2, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h05, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h32, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h05, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h30, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'hff, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h3f, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_FLIPFLOP_RST, 8'h00, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h3f, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_PORT_WRITE, 8'h55, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_DATA_READ, 8'h00, 8'h00, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_SET, 8'hff, 8'h14, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_SET, 8'ha7, 8'h13, 4'd0);
      push_access(vgaac_pkg::CMD_BACKDOOR_SET, 8'h11, 8'hff, 4'd0);
      push_access(vgaac_pkg::CMD_INIT, 8'h00, 8'h00, 4'd8);
      push_access(vgaac_pkg::CMD_INIT, 8'h00, 8'h00, 4'hf);
      push_access(CMD_UNUSED, 8'hff, 8'hff, 4'hf);
      push_access(vgaac_pkg::CMD_INIT, 8'h00, 8'h00, 4'd0);
      wait_quiet();

      // long receiver hold-off while the sender keeps offering: input must back up
      hold_requests++;
      run_phase(0, 0, 40);

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(61, 0, PHASE_ITEMS);
      run_phase(0, 61, PHASE_ITEMS);
      run_phase(20, 20, PHASE_ITEMS);

      wait_quiet();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && status_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
src/vgaac_pkg.sv
src/vgaac_ram.sv
src/vgaac_update.sv
src/vga_attribute_controller.sv
src/vgaac_checker.sv
test/testbench.sv
